FILE: rtl/cfcw_pkg.sv
// Types, face tables and constants shared by the cube face wrap block.
package cfcw_pkg;

    typedef logic [2:0] t_face;
    typedef logic [1:0] t_turn;

    localparam int    NUM_FACES = 6;
    localparam int    NUM_CROSS = 4;
    localparam t_face LAST_FACE = 3'd5;

    localparam t_turn TURN_0 = 2'd0;
    localparam t_turn TURN_1 = 2'd1;
    localparam t_turn TURN_2 = 2'd2;
    localparam t_turn TURN_3 = 2'd3;

    // indexed [start face][crossings mod 4]
    localparam t_face HORIZ_FACE [NUM_FACES][NUM_CROSS] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd1, 3'd2, 3'd3, 3'd0}, '{3'd2, 3'd3, 3'd0, 3'd1},
        '{3'd3, 3'd0, 3'd1, 3'd2}, '{3'd4, 3'd1, 3'd5, 3'd3}, '{3'd5, 3'd1, 3'd4, 3'd3}
    };
    localparam t_turn HORIZ_TURN [NUM_FACES][NUM_CROSS] = '{
        '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd0, 2'd1, 2'd2, 2'd3}
    };
    localparam t_face VERT_FACE [NUM_FACES][NUM_CROSS] = '{
        '{3'd0, 3'd4, 3'd2, 3'd5}, '{3'd1, 3'd4, 3'd3, 3'd5}, '{3'd2, 3'd4, 3'd0, 3'd5},
        '{3'd3, 3'd4, 3'd1, 3'd5}, '{3'd4, 3'd2, 3'd5, 3'd0}, '{3'd5, 3'd0, 3'd4, 3'd2}
    };
    localparam t_turn VERT_TURN [NUM_FACES][NUM_CROSS] = '{
        '{2'd0, 2'd0, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd2, 2'd2},
        '{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd0, 2'd2, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd2}
    };

    // sideband carried through the divider
    typedef struct packed {
        t_face face;
        logic  bad;
        logic  neg_x;
        logic  neg_y;
    } t_side;

endpackage

FILE: rtl/cfcw_if.sv
// Request and result channel interfaces of the cube face wrap block.
interface cfcw_in_if import cfcw_pkg::*; #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    t_face                        in_face;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;

    modport source (output valid, in_face, in_x, in_y, input ready);
    modport sink   (input valid, in_face, in_x, in_y, output ready);
endinterface

interface cfcw_out_if import cfcw_pkg::*; #(
    parameter int EDGE_BITS = 12
) ();
    logic                 valid;
    logic                 ready;
    t_face                out_face;
    logic [EDGE_BITS-1:0] out_x;
    logic [EDGE_BITS-1:0] out_y;
    logic                 bad_face;

    modport source (output valid, out_face, out_x, out_y, bad_face, input ready);
    modport sink   (input valid, out_face, out_x, out_y, bad_face, output ready);
endinterface

FILE: rtl/cfcw_div_pipe.sv
// Pipelined restoring divider: x and y magnitudes by the edge size, one bit per stage.
module cfcw_div_pipe import cfcw_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int EDGE_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  t_side                 i_side,
    input  logic [COORD_BITS-1:0] i_mag_x,
    input  logic [COORD_BITS-1:0] i_mag_y,
    input  logic [EDGE_BITS:0]    i_edge,
    output logic                  o_vld,
    output t_side                 o_side,
    output logic [EDGE_BITS:0]    o_rem_x,
    output logic [EDGE_BITS:0]    o_rem_y,
    output logic [1:0]            o_q_x,
    output logic [1:0]            o_q_y
);

    localparam int EDGE_W = EDGE_BITS + 1;
    localparam int STAGES = COORD_BITS;

    logic [COORD_BITS-1:0] r_mag  [STAGES][2];
    logic [EDGE_W-1:0]     r_rem  [STAGES][2];
    logic [1:0]            r_q    [STAGES][2];
    t_side                 r_side [STAGES];
    logic [STAGES-1:0]     r_vld;

    logic [COORD_BITS-1:0] w_mag  [STAGES][2];
    logic [EDGE_W-1:0]     w_rem  [STAGES][2];
    logic [1:0]            w_q    [STAGES][2];
    t_side                 w_side [STAGES];
    logic [STAGES-1:0]     w_vld;

    logic [EDGE_W-1:0]     n_rem  [STAGES][2];
    logic [1:0]            n_q    [STAGES][2];

    assign w_mag[0][0] = i_mag_x;
    assign w_mag[0][1] = i_mag_y;
    assign w_rem[0][0] = '0;
    assign w_rem[0][1] = '0;
    assign w_q[0][0]   = '0;
    assign w_q[0][1]   = '0;
    assign w_side[0]   = i_side;
    assign w_vld[0]    = i_vld;

    genvar k;
    generate
        for (k = 1; k < STAGES; k++) begin : g_link
            assign w_mag[k][0] = r_mag[k-1][0];
            assign w_mag[k][1] = r_mag[k-1][1];
            assign w_rem[k][0] = r_rem[k-1][0];
            assign w_rem[k][1] = r_rem[k-1][1];
            assign w_q[k][0]   = r_q[k-1][0];
            assign w_q[k][1]   = r_q[k-1][1];
            assign w_side[k]   = r_side[k-1];
            assign w_vld[k]    = r_vld[k-1];
        end
    endgenerate

    // one compare-subtract per stage and lane; only the two low quotient bits are kept
    always_comb begin
        logic [EDGE_W:0] w_t;
        logic            w_ge;
        for (int s = 0; s < STAGES; s++) begin
            for (int j = 0; j < 2; j++) begin
                w_t  = {w_rem[s][j], w_mag[s][j][COORD_BITS-1-s]};
                w_ge = (w_t >= {1'b0, i_edge});
                n_rem[s][j] = w_ge ? EDGE_W'(w_t - {1'b0, i_edge}) : w_t[EDGE_W-1:0];
                n_q[s][j]   = {w_q[s][j][0], w_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STAGES; s++) begin
                r_side[s] <= w_side[s];
                for (int j = 0; j < 2; j++) begin
                    r_mag[s][j] <= w_mag[s][j];
                    r_rem[s][j] <= n_rem[s][j];
                    r_q[s][j]   <= n_q[s][j];
                end
            end
        end
    end

    assign o_vld   = r_vld[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_rem_x = r_rem[STAGES-1][0];
    assign o_rem_y = r_rem[STAGES-1][1];
    assign o_q_x   = r_q[STAGES-1][0];
    assign o_q_y   = r_q[STAGES-1][1];

endmodule

FILE: rtl/cube_face_coordinate_wrap.sv
// Top level: maps an off-face cell position to its face and local coordinates.
// Throughput: one word per cycle while the skid stage is empty; one restoring
// divider stage per coordinate bit. A two-entry output register and skid stage
// decouple the result side. Reset clears all valid bits and loads an edge size
// of 16, capped at 2^EDGE_BITS; no clearing pass.
module cube_face_coordinate_wrap import cfcw_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int EDGE_BITS  = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [EDGE_BITS:0] i_cfg_data,
    cfcw_in_if.sink            i_in,
    cfcw_out_if.source         o_out
);

    localparam int EDGE_W   = EDGE_BITS + 1;
    localparam int EDGE_MAX = 2 ** EDGE_BITS;
    localparam int EDGE_RST = (16 > EDGE_MAX) ? EDGE_MAX : 16;

    typedef struct packed {
        t_face                face;
        t_turn                turn;
        logic [EDGE_BITS-1:0] rx;
        logic [EDGE_BITS-1:0] ry;
        logic                 bad;
    } t_f1;

    typedef struct packed {
        t_face                face;
        logic [EDGE_BITS-1:0] x;
        logic [EDGE_BITS-1:0] y;
        logic                 bad;
    } t_result;

    // edge size, stored already clamped to 1..2^EDGE_BITS
    logic [EDGE_W-1:0]    r_edge;
    logic [EDGE_BITS-1:0] r_mlast;
    logic [EDGE_W-1:0]    n_edge;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_edge = EDGE_W'(1);
        end else if (i_cfg_data > EDGE_W'(EDGE_MAX)) begin
            n_edge = EDGE_W'(EDGE_MAX);
        end else begin
            n_edge = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge  <= EDGE_W'(EDGE_RST);
            r_mlast <= EDGE_BITS'(EDGE_RST - 1);
        end else if (i_cfg_we) begin
            r_edge  <= n_edge;
            r_mlast <= EDGE_BITS'(n_edge - EDGE_W'(1));
        end
    end

    logic w_en;
    logic r_skid_vld;
    logic r_out_vld;

    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;

    // input stage: sign split and magnitudes
    logic                  r_s0_vld;
    t_side                 r_s0_side;
    logic [COORD_BITS-1:0] r_s0_mag_x;
    logic [COORD_BITS-1:0] r_s0_mag_y;
    t_side                 n_s0_side;
    logic [COORD_BITS-1:0] n_s0_mag_x;
    logic [COORD_BITS-1:0] n_s0_mag_y;

    always_comb begin
        n_s0_side.face  = i_in.in_face;
        n_s0_side.bad   = (i_in.in_face > LAST_FACE);
        n_s0_side.neg_x = i_in.in_x[COORD_BITS-1];
        n_s0_side.neg_y = i_in.in_y[COORD_BITS-1];
        n_s0_mag_x = n_s0_side.neg_x ? COORD_BITS'(~i_in.in_x + 1'b1) : COORD_BITS'(i_in.in_x);
        n_s0_mag_y = n_s0_side.neg_y ? COORD_BITS'(~i_in.in_y + 1'b1) : COORD_BITS'(i_in.in_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side  <= n_s0_side;
            r_s0_mag_x <= n_s0_mag_x;
            r_s0_mag_y <= n_s0_mag_y;
        end
    end

    logic              w_dv_vld;
    t_side             w_dv_side;
    logic [EDGE_W-1:0] w_rem_x;
    logic [EDGE_W-1:0] w_rem_y;
    logic [1:0]        w_q_x;
    logic [1:0]        w_q_y;

    cfcw_div_pipe #(
        .COORD_BITS (COORD_BITS),
        .EDGE_BITS  (EDGE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s0_vld),
        .i_side  (r_s0_side),
        .i_mag_x (r_s0_mag_x),
        .i_mag_y (r_s0_mag_y),
        .i_edge  (r_edge),
        .o_vld   (w_dv_vld),
        .o_side  (w_dv_side),
        .o_rem_x (w_rem_x),
        .o_rem_y (w_rem_y),
        .o_q_x   (w_q_x),
        .o_q_y   (w_q_y)
    );

    // floor correction for negative inputs, then table lookup
    logic  r_f1_vld;
    t_f1   r_f1;
    t_f1   n_f1;

    always_comb begin
        logic  nz_x;
        logic  nz_y;
        t_turn h;
        t_turn v;
        t_face fidx;
        t_face hface;
        nz_x = (w_rem_x != '0);
        nz_y = (w_rem_y != '0);
        if (w_dv_side.neg_x) begin
            h = nz_x ? ~w_q_x : 2'(~w_q_x + 2'd1);
        end else begin
            h = w_q_x;
        end
        if (w_dv_side.neg_y) begin
            v = nz_y ? ~w_q_y : 2'(~w_q_y + 2'd1);
        end else begin
            v = w_q_y;
        end
        n_f1.rx = (w_dv_side.neg_x && nz_x) ? EDGE_BITS'(r_edge - w_rem_x)
                                             : EDGE_BITS'(w_rem_x);
        n_f1.ry = (w_dv_side.neg_y && nz_y) ? EDGE_BITS'(r_edge - w_rem_y)
                                             : EDGE_BITS'(w_rem_y);
        fidx      = w_dv_side.bad ? t_face'(0) : w_dv_side.face;
        hface     = HORIZ_FACE[fidx][h];
        n_f1.face = VERT_FACE[hface][v];
        n_f1.turn = t_turn'(HORIZ_TURN[fidx][h] + VERT_TURN[fidx][v]);
        n_f1.bad  = w_dv_side.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1 <= n_f1;
        end
    end

    // quarter-turn rotation about the face center
    t_result n_res;

    always_comb begin
        logic [EDGE_BITS-1:0] mx;
        logic [EDGE_BITS-1:0] my;
        mx = r_mlast - r_f1.rx;
        my = r_mlast - r_f1.ry;
        n_res.face = r_f1.face;
        n_res.bad  = r_f1.bad;
        case (r_f1.turn)
            TURN_1: begin
                n_res.x = my;
                n_res.y = r_f1.rx;
            end
            TURN_2: begin
                n_res.x = mx;
                n_res.y = my;
            end
            TURN_3: begin
                n_res.x = r_f1.ry;
                n_res.y = mx;
            end
            default: begin
                n_res.x = r_f1.rx;
                n_res.y = r_f1.ry;
            end
        endcase
        if (r_f1.bad) begin
            n_res.face = '0;
            n_res.x    = '0;
            n_res.y    = '0;
        end
    end

    // output register with skid stage
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (o_out.ready || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_f1_vld;
            end
        end else if (r_f1_vld && w_en) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out.ready || !r_out_vld) begin
            r_out <= r_skid_vld ? r_skid : n_res;
        end else if (w_en) begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.out_face = r_out.face;
    assign o_out.out_x    = r_out.x;
    assign o_out.out_y    = r_out.y;
    assign o_out.bad_face = r_out.bad;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held with empty output register");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_s0_vld)
        else $error("accepted word missing from input stage");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_face |->
            o_out.out_face == '0 && o_out.out_x == '0 && o_out.out_y == '0)
        else $error("bad face word carries nonzero fields");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.bad_face |-> o_out.out_face <= LAST_FACE)
        else $error("destination face out of range");

    a_local_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.bad_face |->
            {1'b0, o_out.out_x} < r_edge && {1'b0, o_out.out_y} < r_edge)
        else $error("local coordinate beyond edge");

endmodule

FILE: bench/cube_face_coordinate_wrap_tb.sv
// Self-checking testbench for cube_face_coordinate_wrap: directed and random words.
`timescale 1ns / 100ps

module cube_face_coordinate_wrap_tb import cfcw_pkg::*; ();

    localparam int COORD_BITS  = 16;
    localparam int EDGE_BITS   = 12;
    localparam int EDGE_MAX    = 1 << EDGE_BITS;
    localparam int LATENCY     = COORD_BITS + 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;
    localparam int RAND_BLOCK  = 100;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [EDGE_BITS:0] edge_reg_t;
    typedef enum logic [1:0] {QT_NONE, QT_ONE, QT_HALF, QT_THREE} quarter_t;

    typedef struct packed {
        t_face                face;
        logic [EDGE_BITS-1:0] x;
        logic [EDGE_BITS-1:0] y;
        logic                 bad;
    } cell_addr_t;

    // [start face][crossings mod 4]
    localparam logic [2:0] FACE_AFTER_H [6][4] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd1, 3'd2, 3'd3, 3'd0}, '{3'd2, 3'd3, 3'd0, 3'd1},
        '{3'd3, 3'd0, 3'd1, 3'd2}, '{3'd4, 3'd1, 3'd5, 3'd3}, '{3'd5, 3'd1, 3'd4, 3'd3}
    };
    localparam logic [1:0] TURN_AFTER_H [6][4] = '{
        '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd0, 2'd1, 2'd2, 2'd3}
    };
    localparam logic [2:0] FACE_AFTER_V [6][4] = '{
        '{3'd0, 3'd4, 3'd2, 3'd5}, '{3'd1, 3'd4, 3'd3, 3'd5}, '{3'd2, 3'd4, 3'd0, 3'd5},
        '{3'd3, 3'd4, 3'd1, 3'd5}, '{3'd4, 3'd2, 3'd5, 3'd0}, '{3'd5, 3'd0, 3'd4, 3'd2}
    };
    localparam logic [1:0] TURN_AFTER_V [6][4] = '{
        '{2'd0, 2'd0, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd2, 2'd2},
        '{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd0, 2'd2, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd2}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      cfg_we;
    edge_reg_t cfg_data;

    cfcw_in_if  #(.COORD_BITS(COORD_BITS)) req_if ();
    cfcw_out_if #(.EDGE_BITS(EDGE_BITS))   res_if ();

    cube_face_coordinate_wrap #(
        .COORD_BITS (COORD_BITS),
        .EDGE_BITS  (EDGE_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (req_if),
        .o_out      (res_if)
    );

    edge_reg_t  edge_cfg;
    cell_addr_t addr_q [$];
    int         mismatches = 0;
    int         cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int eff_edge(edge_reg_t value);
        if (value == 0)
            return 1;
        if (value > EDGE_MAX)
            return EDGE_MAX;
        return int'(value);
    endfunction

    function automatic void split_floor(input int p, input int e, output int q, output int r);
        q = p / e;
        if ((p % e) != 0 && p < 0)
            q = q - 1;
        r = p - q * e;
    endfunction

    function automatic cell_addr_t predict_wrap(t_face face, coord_t px, coord_t py,
                                                edge_reg_t edge_value);
        cell_addr_t w;
        int         e, m, qx, rx, qy, ry, nx, ny;
        logic [1:0] h, v;
        quarter_t   turn;

        w = '0;
        if (face > 3'd5) begin
            w.bad = 1'b1;
            return w;
        end
        e = eff_edge(edge_value);
        m = e - 1;
        split_floor(int'(px), e, qx, rx);
        split_floor(int'(py), e, qy, ry);
        h = qx[1:0];
        v = qy[1:0];
        turn = quarter_t'(TURN_AFTER_H[face][h] + TURN_AFTER_V[face][v]);
        case (turn)
            QT_ONE: begin
                nx = m - ry;
                ny = rx;
            end
            QT_HALF: begin
                nx = m - rx;
                ny = m - ry;
            end
            QT_THREE: begin
                nx = ry;
                ny = m - rx;
            end
            default: begin
                nx = rx;
                ny = ry;
            end
        endcase
        w.face = FACE_AFTER_V[FACE_AFTER_H[face][h]][v];
        w.x    = nx[EDGE_BITS-1:0];
        w.y    = ny[EDGE_BITS-1:0];
        return w;
    endfunction

    function automatic t_face rand_face();
        if ($urandom_range(0, 15) == 0)
            return t_face'($urandom_range(6, 7));
        return t_face'($urandom_range(0, 5));
    endfunction

    // half near the face (a few crossings either way), half anywhere in range
    function automatic coord_t rand_coord(int e);
        if ($urandom_range(0, 1) == 1)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(0, 8 * e)) - 4 * e);
    endfunction

    task automatic send_word(t_face face, coord_t x, coord_t y);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.in_face <= face;
        req_if.in_x    <= x;
        req_if.in_y    <= y;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1)
            @(posedge i_clk);
        addr_q.push_back(predict_wrap(face, x, y, edge_cfg));
    endtask

    task automatic set_edge(edge_reg_t value);
        req_if.valid <= 1'b0;
        while (addr_q.size() != 0)
            @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        edge_cfg = value;
    endtask

    task automatic test_reset_edge();
        send_word(3'd0, 0, 0);
        send_word(3'd0, 15, 15);
        send_word(3'd0, 16, 0);
        send_word(3'd0, -1, 0);
        send_word(3'd0, 0, -1);
        send_word(3'd0, 32767, 32767);
        send_word(3'd0, -32768, -32768);
        send_word(3'd4, -32768, 32767);
        send_word(3'd5, 32767, -32768);
        send_word(3'd1, 16, 16);
        send_word(3'd2, -17, 33);
        send_word(3'd3, -40, -50);
        send_word(3'd4, 20, -20);
        send_word(3'd5, -5, 40);
    endtask

    task automatic test_bad_face();
        send_word(3'd6, 0, 0);
        send_word(3'd7, -1, -1);
    endtask

    task automatic test_edge_limits();
        // zero acts as one cell, oversize saturates to the largest face
        set_edge('0);
        send_word(3'd0, 3, -2);
        send_word(3'd4, -1, 1);
        set_edge('1);
        send_word(3'd5, -1, -1);
        send_word(3'd4, 4096, -4097);
        set_edge(1);
        send_word(3'd1, -3, 2);
        send_word(3'd5, 7, 6);
    endtask

    task automatic test_random_traffic();
        int plan [12] = '{1, 2, 3, 4096, 8191, 0, 5, 16, 100, 4095, -1, -1};
        int pick;
        int e;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 59;
                end
                1: begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 10;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int s = 0; s < 4; s++) begin
                pick = plan[phase * 4 + s];
                if (pick < 0)
                    pick = $urandom_range(1, 300);
                set_edge(edge_reg_t'(pick));
                e = eff_edge(edge_cfg);
                repeat (RAND_BLOCK)
                    send_word(rand_face(), rand_coord(e), rand_coord(e));
            end
        end
    endtask

    always @(posedge i_clk)
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk) begin : check_results
        cell_addr_t want;
        cell_addr_t got;

        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got = '{res_if.out_face, res_if.out_x, res_if.out_y, res_if.bad_face};
            if (addr_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected word: face %0d x %0d y %0d bad %0b",
                             got.face, got.x, got.y, got.bad);
            end else begin
                want = addr_q.pop_front();
                if (got.face !== want.face || got.x !== want.x || got.y !== want.y
                        || got.bad !== want.bad) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("word mismatch: exp face %0d x %0d y %0d bad %0b, ",
                                 want.face, want.x, want.y, want.bad,
                                 "got face %0d x %0d y %0d bad %0b",
                                 got.face, got.x, got.y, got.bad);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_data       <= '0;
        req_if.valid   <= 1'b0;
        req_if.in_face <= '0;
        req_if.in_x    <= '0;
        req_if.in_y    <= '0;
        edge_cfg       = 16;
        send_idle_pct  = 10;
        recv_stall_pct = 59;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_edge();
        test_bad_face();
        test_edge_limits();
        test_random_traffic();

        req_if.valid <= 1'b0;
        while (addr_q.size() != 0)
            @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (mismatches == 0 && addr_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
